// ===== hdl/msacf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msacf_pkg
// Shared sizes and controller/datapath interface types for the mark sorter.
// ----------------------------------------------------------------------------
package msacf_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int MARK_W      = 10;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic [MARK_W-1:0] PASS_MARK_RST = MARK_W'(40);

   typedef logic [MARK_W-1:0] mark_type;
   typedef logic [CNT_W-1:0]  count_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // insert req mark into the sorted chain
      logic shift;       // pop the head entry
      logic clear;       // end of run: empty the store, drop overflow flag
      logic emit_pass;   // register head as a passing result
      logic emit_empty;  // register the empty result
      logic emit_last;   // result being registered closes the run
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic head_pass;   // head entry valid and at or above pass mark
      logic next_pass;   // second entry valid and at or above pass mark
   } dp_stat_type;

endpackage

// ===== hdl/msacf_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msacf_dpath
// Insertion-sort chain of mark cells, pass mark register and result registers.
// ----------------------------------------------------------------------------
module msacf_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  msacf_pkg::mark_type  req_mark,
   input  logic                 csr_wr_en,
   input  msacf_pkg::mark_type  csr_wr_data,
   input  msacf_pkg::dp_cmd_type cmd,
   output msacf_pkg::dp_stat_type stat,
   output msacf_pkg::mark_type  rsp_sorted_mark,
   output logic                 rsp_last_result,
   output logic                 rsp_none_passed,
   output logic                 rsp_overflowed
);
   import msacf_pkg::*;

   mark_type  cell_ff [MAX_ENTRIES];
   mark_type  ins_in  [MAX_ENTRIES];
   mark_type  pop_in  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] keep;
   logic [MAX_ENTRIES-1:0] prev_keep;

   count_type count_ff, count_in;
   logic      ovf_ff, ovf_in;
   mark_type  pass_ff;
   logic      full;

   mark_type  out_mark_ff;
   logic      out_last_ff, out_none_ff, out_ovf_ff;

   assign full = (count_ff == CNT_W'(MAX_ENTRIES));

   // Cells hold a descending run; new mark lands ahead of the first smaller one.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] >= req_mark);
      end
      prev_keep[0] = 1'b1;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
         prev_keep[i] = keep[i-1];
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (keep[i]) begin
            ins_in[i] = cell_ff[i];
         end else if (prev_keep[i]) begin
            ins_in[i] = req_mark;
         end else begin
            ins_in[i] = (i == 0) ? req_mark : cell_ff[(i == 0) ? 0 : i-1];
         end
      end
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
         pop_in[i] = cell_ff[i+1];
      end
      pop_in[MAX_ENTRIES-1] = cell_ff[MAX_ENTRIES-1];
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pass_ff  <= PASS_MARK_RST;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr_wr_en) begin
            pass_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            cell_ff[i] <= ins_in[i];
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            cell_ff[i] <= pop_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pass || cmd.emit_empty) begin
         out_mark_ff <= cmd.emit_empty ? '0 : cell_ff[0];
         out_last_ff <= cmd.emit_last || cmd.emit_empty;
         out_none_ff <= cmd.emit_empty;
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign stat.head_pass = (count_ff != '0) && (cell_ff[0] >= pass_ff);
   assign stat.next_pass = (count_ff > CNT_W'(1)) && (cell_ff[1] >= pass_ff);

   assign rsp_sorted_mark = out_mark_ff;
   assign rsp_last_result = out_last_ff;
   assign rsp_none_passed = out_none_ff;
   assign rsp_overflowed  = out_ovf_ff;

endmodule

// ===== hdl/msacf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msacf_ctrl
// Load/drain sequencer: takes marks, then walks the sorted head out.
// ----------------------------------------------------------------------------
module msacf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_last_mark,
   input  msacf_pkg::dp_stat_type stat,
   output msacf_pkg::dp_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import msacf_pkg::*;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last_mark) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            strobe_in = 1'b1;
            if (stat.head_pass) begin
               cmd.emit_pass = 1'b1;
               cmd.shift     = 1'b1;
               cmd.emit_last = !stat.next_pass;
            end else begin
               // only reachable on the first drain cycle: nothing passed
               cmd.emit_empty = 1'b1;
            end
            if (!stat.head_pass || !stat.next_pass) begin
               cmd.clear = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_LOAD);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== hdl/mark_sort_and_cutoff_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mark_sort_and_cutoff_filter_top
// Marks enter one per cycle, while not busy, into an insertion-sort cell chain.
// After the last mark the FSM drains the chain, registering each result.
// Throughput: then one result per cycle, head of the chain popped each cycle;
// busy stays high while the run drains and is low again at the final result.
// Reset: synchronous, clears count, overflow flag, FSM; pass mark returns to 40.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module mark_sort_and_cutoff_filter_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  msacf_pkg::mark_type  req_mark,
   input  logic                 req_last_mark,
   output logic                 rsp_strobe,
   output msacf_pkg::mark_type  rsp_sorted_mark,
   output logic                 rsp_last_result,
   output logic                 rsp_none_passed,
   output logic                 rsp_overflowed,
   input  logic                 csr_wr_en,
   input  msacf_pkg::mark_type  csr_wr_data
);
   import msacf_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   msacf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_mark (req_last_mark),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe)
   );

   msacf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_mark        (req_mark),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_sorted_mark (rsp_sorted_mark),
      .rsp_last_result (rsp_last_result),
      .rsp_none_passed (rsp_none_passed),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule

// ===== hdl/msacf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msacf_checker
// Port-level checks on run framing for the mark sorter.
// ----------------------------------------------------------------------------
module msacf_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_last_mark,
   input logic                rsp_strobe,
   input msacf_pkg::mark_type rsp_sorted_mark,
   input logic                rsp_last_result,
   input logic                rsp_none_passed
);
   import msacf_pkg::*;

   // nothing in flight right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or strobe after reset");

   // an item that is not last produces no result
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_mark) |=> !rsp_strobe)
      else $error("result after a non-final item");

   // the empty result is alone and zero
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_none_passed) |-> (rsp_last_result && rsp_sorted_mark == '0))
      else $error("malformed empty result");

   // results of one run come back to back
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_result) |=> rsp_strobe)
      else $error("gap inside a run");

   // final result means the block is ready again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_result) |-> !busy)
      else $error("still busy at final result");

endmodule

bind mark_sort_and_cutoff_filter_top msacf_checker u_msacf_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_last_mark   (req_last_mark),
   .rsp_strobe      (rsp_strobe),
   .rsp_sorted_mark (rsp_sorted_mark),
   .rsp_last_result (rsp_last_result),
   .rsp_none_passed (rsp_none_passed)
);

// ===== test/mark_sort_and_cutoff_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mark_sort_and_cutoff_filter_checker
// Watches the mark, result and pass-mark ports of the sorter, keeps its own
// copy of the stored set and ranks it on every closing mark. Each result strobe
// is checked field by field against the oldest ranked mark still owed.
// ----------------------------------------------------------------------------
module mark_sort_and_cutoff_filter_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  msacf_pkg::mark_type  req_mark,
   input  logic                 req_last_mark,
   input  logic                 rsp_strobe,
   input  msacf_pkg::mark_type  rsp_sorted_mark,
   input  logic                 rsp_last_result,
   input  logic                 rsp_none_passed,
   input  logic                 rsp_overflowed,
   input  logic                 csr_wr_en,
   input  msacf_pkg::mark_type  csr_wr_data,
   output int                   mismatch_count,
   output int                   ranked_outstanding,
   output int                   ranked_checked
);

   import msacf_pkg::*;

   typedef struct {
      mark_type mark;
      logic     last;
      logic     none;
      logic     ovf;
   } ranked_mark_type;

   ranked_mark_type ranked_marks_q[$];

   mark_type set_marks[MAX_ENTRIES];
   int       set_size;
   logic     set_dropped;
   mark_type cutoff;

   initial begin
      mismatch_count     = 0;
      ranked_outstanding = 0;
      ranked_checked     = 0;
      set_size           = 0;
      set_dropped        = 1'b0;
      cutoff             = PASS_MARK_RST;
   end

   // sort the held set high to low and queue every mark that reaches the cutoff, or an empty result if none does
   task automatic rank_and_cut_set();
      mark_type        v[MAX_ENTRIES];
      mark_type        key;
      int              j;
      int              npass;
      ranked_mark_type r;
      for (int i = 0; i < MAX_ENTRIES; i++) v[i] = set_marks[i];
      for (int i = 1; i < set_size; i++) begin
         key = v[i];
         j   = i;
         while (j > 0 && v[j-1] < key) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = key;
      end
      npass = 0;
      while (npass < set_size && v[npass] >= cutoff) npass++;
      for (int i = 0; i < npass; i++) begin
         r.mark = v[i];
         r.last = (i == npass - 1);
         r.none = 1'b0;
         r.ovf  = set_dropped;
         ranked_marks_q.push_back(r);
      end
      if (npass == 0) begin
         r.mark = '0;
         r.last = 1'b1;
         r.none = 1'b1;
         r.ovf  = set_dropped;
         ranked_marks_q.push_back(r);
      end
      set_size    = 0;
      set_dropped = 1'b0;
   endtask

   task automatic take_mark(input mark_type m, input logic closes);
      if (set_size < MAX_ENTRIES) begin
         set_marks[set_size] = m;
         set_size++;
      end else begin
         set_dropped = 1'b1;
      end
      if (closes) rank_and_cut_set();
   endtask

   task automatic check_result();
      ranked_mark_type exp;
      if (ranked_marks_q.size() == 0) begin
         if (mismatch_count < 10)
            $display("%0t: result with nothing owed: mark %0d last %b none %b ovf %b",
                     $realtime, rsp_sorted_mark, rsp_last_result, rsp_none_passed,
                     rsp_overflowed);
         mismatch_count++;
      end else begin
         exp = ranked_marks_q.pop_front();
         ranked_checked++;
         if (rsp_sorted_mark !== exp.mark || rsp_last_result !== exp.last ||
             rsp_none_passed !== exp.none || rsp_overflowed !== exp.ovf) begin
            if (mismatch_count < 10) begin
               $display("%0t: result mismatch: exp mark %0d last %b none %b ovf %b",
                        $realtime, exp.mark, exp.last, exp.none, exp.ovf);
               $display("   got mark %0d last %b none %b ovf %b",
                        rsp_sorted_mark, rsp_last_result, rsp_none_passed,
                        rsp_overflowed);
            end
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cutoff      = PASS_MARK_RST;
         set_size    = 0;
         set_dropped = 1'b0;
         ranked_marks_q.delete();
      end else begin
         if (csr_wr_en) cutoff = csr_wr_data;
         if (rsp_strobe) check_result();
         if (start && !busy) take_mark(req_mark, req_last_mark);
      end
      ranked_outstanding = ranked_marks_q.size();
   end

endmodule

// ===== test/tb_mark_sort_and_cutoff_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mark_sort_and_cutoff_filter_top
// Drives mark sets and pass-mark writes into the sorter: a directed opening on
// field extremes, cutoff edges, no-pass and single-mark sets, then random sets
// of mixed size including full and overflowing ones, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_mark_sort_and_cutoff_filter_top;

   import msacf_pkg::*;

   localparam int MARK_MAX = (1 << MARK_W) - 1;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   mark_type req_mark;
   logic     req_last_mark;
   logic     rsp_strobe;
   mark_type rsp_sorted_mark;
   logic     rsp_last_result;
   logic     rsp_none_passed;
   logic     rsp_overflowed;
   logic     csr_wr_en;
   mark_type csr_wr_data;

   int mismatch_count;
   int ranked_outstanding;
   int ranked_checked;

   int       marks_sent;
   int       sets_sent;
   int       overflow_sets;
   int       cutoff_writes;
   mark_type cur_cutoff;
   mark_type prev_mark;

   mark_sort_and_cutoff_filter_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mark        (req_mark),
      .req_last_mark   (req_last_mark),
      .rsp_strobe      (rsp_strobe),
      .rsp_sorted_mark (rsp_sorted_mark),
      .rsp_last_result (rsp_last_result),
      .rsp_none_passed (rsp_none_passed),
      .rsp_overflowed  (rsp_overflowed),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   mark_sort_and_cutoff_filter_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mark           (req_mark),
      .req_last_mark      (req_last_mark),
      .rsp_strobe         (rsp_strobe),
      .rsp_sorted_mark    (rsp_sorted_mark),
      .rsp_last_result    (rsp_last_result),
      .rsp_none_passed    (rsp_none_passed),
      .rsp_overflowed     (rsp_overflowed),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .ranked_outstanding (ranked_outstanding),
      .ranked_checked     (ranked_checked)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // entered and left just after a falling edge; start stays high into a
   // back-to-back item so it is never dropped and raised in the same step
   task automatic drive_item(input mark_type m, input logic closes);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) begin
            req_mark      <= mark_type'($urandom);
            req_last_mark <= 1'($urandom);
            @(negedge clock);
         end
      end
      start         <= 1'b1;
      req_mark      <= m;
      req_last_mark <= closes;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      marks_sent++;
      prev_mark = m;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (ranked_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_cutoff(input mark_type v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_cutoff  = v;
      cutoff_writes++;
   endtask

   function automatic mark_type pick_mark();
      int v;
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, MARK_MAX));
         1: v = int'(cur_cutoff) + int'($urandom_range(0, 4)) - 2;
         2: v = $urandom_range(0, 1) ? MARK_MAX : 0;
         default: v = int'(prev_mark);
      endcase
      if (v < 0) v = 0;
      if (v > MARK_MAX) v = MARK_MAX;
      return mark_type'(v);
   endfunction

   function automatic mark_type pick_cutoff();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return mark_type'(MARK_MAX);
         default: return mark_type'($urandom_range(0, MARK_MAX));
      endcase
   endfunction

   initial begin
      int set_len;
      reset         = 1'b1;
      start         = 1'b0;
      req_mark      = '0;
      req_last_mark = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      marks_sent    = 0;
      sets_sent     = 0;
      overflow_sets = 0;
      cutoff_writes = 0;
      cur_cutoff    = PASS_MARK_RST;
      prev_mark     = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset cutoff: extremes, values around it, a duplicate at the cutoff
      drive_item(mark_type'(MARK_MAX), 1'b0);
      drive_item(mark_type'(0), 1'b0);
      drive_item(mark_type'(40), 1'b0);
      drive_item(mark_type'(39), 1'b0);
      drive_item(mark_type'(41), 1'b0);
      drive_item(mark_type'(40), 1'b1);
      // nothing passes
      drive_item(mark_type'(5), 1'b0);
      drive_item(mark_type'(39), 1'b1);
      // one-mark sets, passing and not
      drive_item(mark_type'(MARK_MAX), 1'b1);
      drive_item(mark_type'(0), 1'b1);
      // cutoff at zero lets a zero mark through
      write_cutoff('0);
      drive_item(mark_type'(0), 1'b0);
      drive_item(mark_type'(682), 1'b0);
      drive_item(mark_type'(341), 1'b1);
      write_cutoff(mark_type'(MARK_MAX));
      drive_item(mark_type'(MARK_MAX - 1), 1'b0);
      drive_item(mark_type'(MARK_MAX), 1'b0);
      drive_item(mark_type'(MARK_MAX), 1'b1);
      sets_sent = 6;

      while (marks_sent < 300) begin
         if (sets_sent == 6 || $urandom_range(0, 3) == 0)
            write_cutoff(pick_cutoff());
         else if ($urandom_range(0, 4) == 0)
            wait_drained();
         // one exactly full set and one overflowing set early on
         if (sets_sent == 6)
            set_len = MAX_ENTRIES;
         else if (sets_sent == 7)
            set_len = MAX_ENTRIES + 3;
         else
            case ($urandom_range(0, 9))
               0: set_len = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 4);
               1: set_len = $urandom_range(9, MAX_ENTRIES - 1);
               default: set_len = $urandom_range(1, 8);
            endcase
         for (int k = 0; k < set_len; k++)
            drive_item(pick_mark(), k == set_len - 1);
         if (set_len > MAX_ENTRIES) overflow_sets++;
         sets_sent++;
      end

      start <= 1'b0;
      while (ranked_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Covered %0d marks in %0d sets (%0d overflowing), %0d pass-mark writes",
               marks_sent, sets_sent, overflow_sets, cutoff_writes);
      $display("Checked %0d ranked results, %0d mismatches",
               ranked_checked, mismatch_count);
      if (mismatch_count == 0 && ranked_outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/msacf_pkg.sv
hdl/msacf_dpath.sv
hdl/msacf_ctrl.sv
hdl/mark_sort_and_cutoff_filter_top.sv
hdl/msacf_checker.sv
test/mark_sort_and_cutoff_filter_checker.sv
test/tb_mark_sort_and_cutoff_filter_top.sv
